@@ rtl/core/ptb_pkg.sv @@
// ----------------------------------------------------------------------------
// ptb_pkg : shared types and constants of the periodic timer bank
// Result kinds, request opcodes, cell control word and default sizing.
// ----------------------------------------------------------------------------
package ptb_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int COUNT_W       = 32;
   localparam int STEP_W        = 12;
   localparam int SLOT_FIELD_W  = 4;
   localparam logic [STEP_W-1:0] STEP_RESET = 12'd1;

   // request word opcodes (req_tuser[0])
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_REGISTER = 1'b1;

   typedef enum logic [1:0] {
      KIND_REGISTERED = 2'd0,
      KIND_REFUSED    = 2'd1,
      KIND_FIRED      = 2'd2
   } kind_type;

   // Broadcast control word from the sequencer to every timer cell.
   typedef struct packed {
      logic               write;    // load period and expiry into the selected cell
      logic               start;    // place the visit token on the newest slot
      logic               step;     // token moves one cell down
      logic               wrapped;  // tick count wrapped on this tick
      logic [COUNT_W-1:0] count;    // current tick count
      logic [COUNT_W-1:0] data;     // interval word for a write
   } ctl_type;

endpackage

@@ rtl/core/ptb_cell.sv @@
// ----------------------------------------------------------------------------
// ptb_cell : one timer slot
// Holds period and expiry, takes the visit token from its upper neighbour.
// ----------------------------------------------------------------------------
module ptb_cell (
   input  logic             clock,
   input  logic             reset,
   input  ptb_pkg::ctl_type ctl,
   input  logic             write_sel,
   input  logic             start_sel,
   input  logic             token_in,
   output logic             token_out,
   output logic             fire
);
   import ptb_pkg::*;

   logic               token_ff, token_in_nxt;
   logic [COUNT_W-1:0] period_ff;
   logic [COUNT_W-1:0] expiry_ff;
   logic               due;

   assign due       = ctl.wrapped || (ctl.count >= expiry_ff);
   assign fire      = token_ff && due;
   assign token_out = token_ff;

   always_comb begin
      token_in_nxt = token_ff;
      if (ctl.start) begin
         token_in_nxt = start_sel;
      end else if (ctl.step) begin
         token_in_nxt = token_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else begin
         token_ff <= token_in_nxt;
      end
   end

   // payload, no reset: only claimed slots are ever visited
   always_ff @(posedge clock) begin
      if (ctl.write && write_sel) begin
         period_ff <= ctl.data;
         expiry_ff <= ctl.count + ctl.data;
      end else if (ctl.step && fire) begin
         expiry_ff <= ctl.count + period_ff;
      end
   end

endmodule

@@ rtl/core/ptb_chain.sv @@
// ----------------------------------------------------------------------------
// ptb_chain : row of timer cells
// Token walks from the newest claimed slot down to slot 0, one cell a cycle unless the walk is stalled.
// ----------------------------------------------------------------------------
module ptb_chain #(
   parameter int SLOTS  = ptb_pkg::SLOTS_DEF,
   parameter int USED_W = $clog2(SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  ptb_pkg::ctl_type  ctl,
   input  logic [USED_W-1:0] used,
   output logic              fire_any
);
   import ptb_pkg::*;

   logic [SLOTS-1:0] token;
   logic [SLOTS-1:0] fire;
   logic [SLOTS:0]   token_link;

   assign token_link[SLOTS] = 1'b0;   // nothing above the top cell

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ptb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .write_sel (used == USED_W'(i)),
         .start_sel (used == USED_W'(i + 1)),
         .token_in  (token_link[i+1]),
         .token_out (token[i]),
         .fire      (fire[i])
      );
      assign token_link[i] = token[i];
   end

   assign fire_any = |fire;

   a_token_single : assert property (@(posedge clock) disable iff (reset)
      $onehot0(token))
      else $error("more than one visit token in the chain");

   a_fire_token : assert property (@(posedge clock) disable iff (reset)
      fire_any |-> (token != '0))
      else $error("fire without a visit token");

   a_token_hold : assert property (@(posedge clock) disable iff (reset)
      (!ctl.start && !ctl.step) |=> $stable(token))
      else $error("token moved without a step");

endmodule

@@ rtl/core/periodic_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_bank_top : bank of periodic timers on a 32-bit tick count
// Register word: result passes the pending register, then the output register.
// Tick word: accept, walk (if any slot is claimed) from the newest claimed slot down
//   to slot 0, flush. A fire result is held until the next fire or the flush;
//   back-pressure stalls the walk only while that held result is stuck.
// Reset (synchronous, high): no slots claimed, tick count 0, tick_step 1;
//   slot stores are not cleared, unclaimed slots are never visited.
// ----------------------------------------------------------------------------
module periodic_timer_bank_top #(
   parameter int SLOTS = ptb_pkg::SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] interval
   input  logic [0:0]  req_tuser,   // [0] opcode: 0 tick, 1 register
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] slot, [35:4] tick_count, [39:36] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last result of this request word
   // configuration: tick_step
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);
   import ptb_pkg::*;

   localparam int USED_W = $clog2(SLOTS + 1);
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               wrapped_ff, wrapped_in;
   logic [STEP_W-1:0]  step_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   // pending result: held until the next fire or the flush so tlast can be decided
   logic               pend_valid_ff, pend_valid_in;
   kind_type           pend_kind_ff, pend_kind_in;
   logic [SLOT_FIELD_W-1:0] pend_slot_ff, pend_slot_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   ctl_type            ctl;
   logic               fire_any;
   logic               accept;
   logic               out_free;
   logic               push;
   logic               push_last;
   logic               walk_step;
   logic [COUNT_W:0]   tick_sum;
   logic [USED_W-1:0]  used_m1;
   logic [IDX_W+SLOT_FIELD_W-1:0]  idx_ext;
   logic [USED_W+SLOT_FIELD_W-1:0] used_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // walk advances unless a held result has nowhere to go
   assign walk_step  = (state_ff == ST_WALK) && (!pend_valid_ff || out_free);

   assign tick_sum = {1'b0, count_ff} + {{(COUNT_W + 1 - STEP_W){1'b0}}, step_ff};
   assign used_m1  = used_ff - USED_W'(1);
   // slot numbers are reported modulo 16
   assign idx_ext  = {{SLOT_FIELD_W{1'b0}}, idx_ff};
   assign used_ext = {{SLOT_FIELD_W{1'b0}}, used_ff};

   always_comb begin
      ctl.write   = accept && (req_tuser[0] == OP_REGISTER) && (used_ff < USED_W'(SLOTS));
      ctl.start   = accept && (req_tuser[0] == OP_TICK);
      ctl.step    = walk_step;
      ctl.wrapped = wrapped_ff;
      ctl.count   = count_ff;
      ctl.data    = req_tdata;
   end

   ptb_chain #(
      .SLOTS  (SLOTS),
      .USED_W (USED_W)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .used     (used_ff),
      .fire_any (fire_any)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      wrapped_in    = wrapped_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == OP_REGISTER) begin
                  pend_valid_in = 1'b1;
                  if (used_ff < USED_W'(SLOTS)) begin
                     pend_kind_in = KIND_REGISTERED;
                     pend_slot_in = used_ext[SLOT_FIELD_W-1:0];
                     used_in      = used_ff + USED_W'(1);
                  end else begin
                     pend_kind_in = KIND_REFUSED;
                     pend_slot_in = '0;
                  end
                  state_in = ST_FLUSH;
               end else begin
                  count_in   = tick_sum[COUNT_W-1:0];
                  wrapped_in = tick_sum[COUNT_W];
                  idx_in     = used_m1[IDX_W-1:0];
                  state_in   = (used_ff != '0) ? ST_WALK : ST_FLUSH;
               end
            end
         end
         ST_WALK: begin
            if (walk_step) begin
               if (fire_any) begin
                  // older held result is not last: another one follows
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_kind_in  = KIND_FIRED;
                  pend_slot_in  = idx_ext[SLOT_FIELD_W-1:0];
               end
               if (idx_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;      // tick with nothing due
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: loads from the pending slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = push;
      end
      if (push) begin
         rsp_kind_in  = pend_kind_ff;
         rsp_slot_in  = pend_slot_ff;
         rsp_count_in = count_ff;
         rsp_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         count_ff      <= '0;
         wrapped_ff    <= 1'b0;
         step_ff       <= STEP_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         count_ff      <= count_in;
         wrapped_ff    <= wrapped_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            step_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_slot_ff};

   a_idle_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held result left over in idle");

   a_used_range : assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(SLOTS))
      else $error("slot count beyond table size");

   a_walk_stall : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && pend_valid_ff && rsp_valid_ff && !rsp_tready)
      |=> $stable(idx_ff) && (state_ff == ST_WALK))
      else $error("walk advanced while output blocked");

endmodule
